// ===== sv/ale_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants for the APN label encoder.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int LABEL_DEPTH = 63;
  localparam int LBL_AW      = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
  localparam int CNT_W       = $clog2(LABEL_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [BYTE_W-1:0] DOT_CHAR      = 8'd46;
  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd100;

  // Register index taken from paddr[2]
  localparam logic REG_MAX_OUTPUT_LEN = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_READ,
    S_DATA
  } state_t;

  typedef struct packed {
    logic              we;
    logic [LBL_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ale_wr_t;

  typedef struct packed {
    logic              re;
    logic [LBL_AW-1:0] addr;
  } ale_rd_t;

endpackage

// ===== sv/apn_label_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apn_label_encoder
// Converts a dotted name, one character per beat, into length-prefixed labels.
// ----------------------------------------------------------------------------
// Usage: characters arrive on the in_ channel, one per beat, and the name is
// closed by a beat with in_is_end set. Characters are buffered in a 63-entry
// label RAM. A dot or the end beat starts a flush: the length byte and then
// each buffered character leave on the out_ channel, one byte per beat. The
// final byte of a name carries out_run_last and, without error, the encoded
// length on out_total_len. An overrun of max_output_len or of the label
// buffer makes the end beat give a single result with out_error set.
// Flow: a flush sends the length byte from S_LEN, then each character by
// way of S_READ and S_DATA, paced by the single RAM read port (a read
// state and an output state per byte); in_ready is low meanwhile.
// Each result is formed and then held in an output register.
// If the receiver stalls, the sequencer waits with the byte held; the next
// character can be taken while the final result is still waiting.
// Reset (synchronous, rst_n low) clears the label count, sets the encoded
// count to 1 and max_output_len to 100; no clearing pass is needed for the RAM.
// ----------------------------------------------------------------------------
module apn_label_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ale_pkg::BYTE_W-1:0]  in_symbol,
  input  logic                        in_is_end,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ale_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_run_last,
  output logic                        out_error,
  output logic [ale_pkg::BYTE_W-1:0]  out_total_len,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ale_pkg::CFG_AW-1:0]  paddr,
  input  logic [ale_pkg::CFG_DW-1:0]  pwdata,
  output logic [ale_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  logic [ale_pkg::BYTE_W-1:0] max_len_r;
  logic                       cfg_wr;
  logic                       cfg_hit;
  ale_pkg::ale_wr_t           wr;
  ale_pkg::ale_rd_t           rd;
  logic [ale_pkg::BYTE_W-1:0] rd_data;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == ale_pkg::REG_MAX_OUTPUT_LEN);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? ale_pkg::CFG_DW'(max_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ale_pkg::MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_r <= pwdata[ale_pkg::BYTE_W-1:0];
    end
  end

  ale_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .max_len       (max_len_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_symbol     (in_symbol),
    .in_is_end     (in_is_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_error     (out_error),
    .out_total_len (out_total_len),
    .wr            (wr),
    .rd            (rd),
    .rd_data       (rd_data)
  );

  ale_label_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  // An error result is always the last one of its name.
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> out_run_last)
    else $error("error result without run_last");

  // An error result carries neither a byte nor a length.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_byte == '0 && out_total_len == '0))
    else $error("error result with non-zero payload");

  // A clean last result reports at least its own length byte.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_last && !out_error) |-> (out_total_len != '0))
    else $error("last result with zero total length");

  // Only last results carry a total length.
  a_tot_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_last) |-> (out_total_len == '0))
    else $error("total length on a result that is not last");
`endif

endmodule

// ===== sv/ale_label_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_label_ram
// Buffer for the characters of the current label: one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module ale_label_ram (
  input  logic                        clk,
  input  ale_pkg::ale_wr_t            wr,
  input  ale_pkg::ale_rd_t            rd,
  output logic [ale_pkg::BYTE_W-1:0]  rd_data
);

  logic [ale_pkg::BYTE_W-1:0] mem [ale_pkg::LABEL_DEPTH];
  logic [ale_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ale_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_seq
// Sequencer: takes characters, tracks label and encoded counts, and walks
// the label buffer one byte at a time into the output register on a flush.
// ----------------------------------------------------------------------------
module ale_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ale_pkg::BYTE_W-1:0]  max_len,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ale_pkg::BYTE_W-1:0]  in_symbol,
  input  logic                        in_is_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ale_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_run_last,
  output logic                        out_error,
  output logic [ale_pkg::BYTE_W-1:0]  out_total_len,
  output ale_pkg::ale_wr_t            wr,
  output ale_pkg::ale_rd_t            rd,
  input  logic [ale_pkg::BYTE_W-1:0]  rd_data
);

  localparam int CW = ale_pkg::CNT_W;
  localparam int BW = ale_pkg::BYTE_W;

  ale_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] label_cnt_r, label_cnt_nxt;
  logic [BW-1:0] enc_cnt_r, enc_cnt_nxt;
  logic          failed_r, failed_nxt;
  logic [CW-1:0] fl_cnt_r, fl_cnt_nxt;
  logic [BW-1:0] fl_tot_r, fl_tot_nxt;
  logic          fl_final_r, fl_final_nxt;
  logic          fl_err_r, fl_err_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_err_r, out_err_nxt;
  logic [BW-1:0] out_tot_r, out_tot_nxt;

  logic          acc;
  logic          slot_free;
  logic          is_dot;
  logic          lim_hit;
  logic          lbl_full;
  logic          start_flush;
  logic          len_only;
  logic          last_data;
  logic [CW-1:0] idx_inc;

  assign in_ready    = (state_r == ale_pkg::S_IDLE);
  assign acc         = in_valid && in_ready;
  assign slot_free   = !out_valid_r || out_ready;
  assign is_dot      = (in_symbol == ale_pkg::DOT_CHAR);
  assign lim_hit     = (enc_cnt_r >= max_len);
  assign lbl_full    = (label_cnt_r >= CW'(ale_pkg::LABEL_DEPTH));
  assign start_flush = acc && (in_is_end || (!failed_r && !lim_hit && is_dot));
  assign len_only    = fl_err_r || (fl_cnt_r == '0);
  assign idx_inc     = idx_r + CW'(1);
  assign last_data   = (idx_inc == fl_cnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ale_pkg::S_IDLE: begin
        if (start_flush) begin
          state_nxt = ale_pkg::S_LEN;
        end
      end
      ale_pkg::S_LEN: begin
        if (slot_free) begin
          state_nxt = len_only ? ale_pkg::S_IDLE : ale_pkg::S_READ;
        end
      end
      ale_pkg::S_READ: begin
        state_nxt = ale_pkg::S_DATA;
      end
      ale_pkg::S_DATA: begin
        if (slot_free) begin
          state_nxt = last_data ? ale_pkg::S_IDLE : ale_pkg::S_READ;
        end
      end
      default: begin
        state_nxt = ale_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    label_cnt_nxt = label_cnt_r;
    enc_cnt_nxt   = enc_cnt_r;
    failed_nxt    = failed_r;
    fl_cnt_nxt    = fl_cnt_r;
    fl_tot_nxt    = fl_tot_r;
    fl_final_nxt  = fl_final_r;
    fl_err_nxt    = fl_err_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    out_tot_nxt   = out_tot_r;
    wr.we         = 1'b0;
    wr.addr       = label_cnt_r[ale_pkg::LBL_AW-1:0];
    wr.data       = in_symbol;
    rd.re         = 1'b0;
    rd.addr       = idx_r[ale_pkg::LBL_AW-1:0];

    case (state_r)
      ale_pkg::S_IDLE: begin
        idx_nxt = '0;
        if (acc) begin
          if (in_is_end) begin
            fl_cnt_nxt    = label_cnt_r;
            fl_tot_nxt    = enc_cnt_r;
            fl_final_nxt  = 1'b1;
            fl_err_nxt    = failed_r || (max_len == '0);
            label_cnt_nxt = '0;
            enc_cnt_nxt   = BW'(1);
            failed_nxt    = 1'b0;
          end else if (!failed_r) begin
            if (lim_hit) begin
              failed_nxt = 1'b1;
            end else if (is_dot) begin
              enc_cnt_nxt   = enc_cnt_r + BW'(1);
              fl_cnt_nxt    = label_cnt_r;
              fl_tot_nxt    = enc_cnt_r;
              fl_final_nxt  = 1'b0;
              fl_err_nxt    = 1'b0;
              label_cnt_nxt = '0;
            end else if (lbl_full) begin
              failed_nxt = 1'b1;
            end else begin
              wr.we         = 1'b1;
              label_cnt_nxt = label_cnt_r + CW'(1);
              enc_cnt_nxt   = enc_cnt_r + BW'(1);
            end
          end
        end
      end
      ale_pkg::S_LEN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = fl_err_r ? '0 : BW'(fl_cnt_r);
          out_last_nxt  = fl_final_r && len_only;
          out_err_nxt   = fl_err_r;
          out_tot_nxt   = (fl_final_r && !fl_err_r && (fl_cnt_r == '0)) ? fl_tot_r : '0;
        end
      end
      ale_pkg::S_READ: begin
        rd.re = 1'b1;
      end
      ale_pkg::S_DATA: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          out_last_nxt  = fl_final_r && last_data;
          out_err_nxt   = 1'b0;
          out_tot_nxt   = (fl_final_r && last_data) ? fl_tot_r : '0;
          idx_nxt       = idx_inc;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ale_pkg::S_IDLE;
      label_cnt_r <= '0;
      enc_cnt_r   <= BW'(1);
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      label_cnt_r <= label_cnt_nxt;
      enc_cnt_r   <= enc_cnt_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fl_cnt_r   <= fl_cnt_nxt;
    fl_tot_r   <= fl_tot_nxt;
    fl_final_r <= fl_final_nxt;
    fl_err_r   <= fl_err_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
    out_tot_r  <= out_tot_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_last_r;
  assign out_error     = out_err_r;
  assign out_total_len = out_tot_r;

endmodule

// ===== tb/apn_label_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apn_label_encoder_tb
// Self-checking bench for the APN label encoder: a directed table of names,
// then random names under several limit settings and idling patterns. Every
// output beat is checked against a typed table beat or a predictor of the encoding.
// ----------------------------------------------------------------------------
module apn_label_encoder_tb;

  localparam int  BW           = ale_pkg::BYTE_W;
  localparam int  CLK_HALF     = 10;
  localparam int  RESET_CYCLES = 12;
  localparam int  STALL_LIMIT  = 4000;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  SETTLE       = 12;
  localparam int  PHASE_ITEMS  = 15;

  typedef struct packed {
    logic [BW-1:0] octet;
    logic          last;
    logic          err;
    logic [BW-1:0] total;
  } encoded_beat_t;

  typedef enum logic { ROW_SEND, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [BW-1:0] symbol;
    logic          is_end;
    logic          typed;
    encoded_beat_t beat;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [BW-1:0]               in_symbol;
  logic                        in_is_end;
  logic                        out_valid;
  logic                        out_ready;
  logic [BW-1:0]               out_byte;
  logic                        out_run_last;
  logic                        out_error;
  logic [BW-1:0]               out_total_len;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ale_pkg::CFG_AW-1:0]  paddr;
  logic [ale_pkg::CFG_DW-1:0]  pwdata;
  logic [ale_pkg::CFG_DW-1:0]  prdata;
  logic                        pready;

  apn_label_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_symbol(in_symbol), .in_is_end(in_is_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .out_run_last(out_run_last),
    .out_error(out_error), .out_total_len(out_total_len),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Predictor state
  logic [BW-1:0] pred_label [ale_pkg::LABEL_DEPTH];
  logic [6:0]    pred_label_cnt;
  logic [8:0]    pred_enc_cnt;
  logic          pred_failed;
  logic [BW-1:0] pred_max_len;

  encoded_beat_t expected_beats [$];
  dir_row_t      dir_table [$];

  int mismatches   = 0;
  int items_sent   = 0;
  int names_sent   = 0;
  int beats_seen   = 0;
  int cfg_writes   = 0;
  int idle_cycles  = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req     = 1'b0;
  int hold_left    = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_beat(input logic [BW-1:0] octet, input logic last,
                           input logic err, input logic [BW-1:0] total,
                           input bit keep);
    encoded_beat_t b;
    b.octet = octet;
    b.last  = last;
    b.err   = err;
    b.total = total;
    if (keep) expected_beats.push_back(b);
  endtask

  task automatic flush_label(input bit final_lbl, input bit keep);
    int  n;
    bit  last;
    n = int'(pred_label_cnt);
    last = final_lbl && (n == 0);
    push_beat({1'b0, pred_label_cnt}, last, 1'b0, last ? pred_enc_cnt[7:0] : 8'd0, keep);
    for (int i = 0; i < n; i++) begin
      last = final_lbl && (i == n - 1);
      push_beat(pred_label[i], last, 1'b0, last ? pred_enc_cnt[7:0] : 8'd0, keep);
    end
    pred_label_cnt = '0;
  endtask

  task automatic restart_name();
    pred_label_cnt = '0;
    pred_enc_cnt   = 9'd1;
    pred_failed    = 1'b0;
  endtask

  // Advances the predicted encoder by one accepted input beat.
  task automatic encode_symbol(input logic [BW-1:0] sym, input logic is_end,
                               input bit keep);
    if (is_end) begin
      if (pred_max_len == '0) pred_failed = 1'b1;
      if (pred_failed) push_beat(8'd0, 1'b1, 1'b1, 8'd0, keep);
      else flush_label(1'b1, keep);
      restart_name();
    end else if (!pred_failed) begin
      if (pred_enc_cnt >= {1'b0, pred_max_len}) begin
        pred_failed = 1'b1;
      end else if (sym == ale_pkg::DOT_CHAR) begin
        pred_enc_cnt++;
        flush_label(1'b0, keep);
      end else if (int'(pred_label_cnt) >= ale_pkg::LABEL_DEPTH) begin
        pred_failed = 1'b1;
      end else begin
        pred_enc_cnt++;
        pred_label[pred_label_cnt[ale_pkg::LBL_AW-1:0]] = sym;
        pred_label_cnt++;
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_symbol(input logic [BW-1:0] sym, input logic is_end,
                             input bit typed, input encoded_beat_t typed_beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_symbol <= BW'($urandom_range(255));
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_is_end <= is_end;
    do @(posedge clk); while (!in_ready);
    encode_symbol(sym, is_end, !typed);
    if (typed) expected_beats.push_back(typed_beat);
    items_sent++;
    if (is_end) names_sent++;
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [BW-1:0] sym, input logic is_end);
    send_symbol(sym, is_end, 1'b0, '0);
  endtask

  function automatic logic [BW-1:0] random_char();
    logic [BW-1:0] c;
    do c = BW'($urandom_range(255)); while (c == ale_pkg::DOT_CHAR);
    return c;
  endfunction

  // Waits for the block to go idle, then writes and reads back the limit.
  task automatic write_max_len(input logic [BW-1:0] value);
    logic [ale_pkg::CFG_DW-1:0] data;
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    data = $urandom;
    data[BW-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ale_pkg::REG_MAX_OUTPUT_LEN, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pred_max_len = value;
    cfg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[BW-1:0] !== value)
      report_mismatch("max_output_len read", int'(prdata[BW-1:0]), int'(value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_limit();
    case ($urandom_range(9))
      0: write_max_len(8'd0);
      1: write_max_len(8'd1);
      2: write_max_len(8'd2);
      3: write_max_len(8'd255);
      4: write_max_len(8'd254);
      5: write_max_len(BW'($urandom_range(3, 30)));
      default: write_max_len(BW'($urandom_range(30, 255)));
    endcase
  endtask

  task automatic send_label(input int len);
    for (int i = 0; i < len; i++) send_plain(random_char(), 1'b0);
  endtask

  task automatic send_random_name();
    int pick;
    int nlab;
    int len;
    pick = $urandom_range(99);
    if (pick < 75) begin
      // Well-formed dotted name with random content
      nlab = $urandom_range(1, 4);
      for (int l = 0; l < nlab; l++) begin
        if (l != 0) send_plain(ale_pkg::DOT_CHAR, 1'b0);
        len = ($urandom_range(19) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
        send_label(len);
      end
    end else if (pick < 90) begin
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++)
        send_plain(($urandom_range(3) == 0) ? ale_pkg::DOT_CHAR : random_char(), 1'b0);
    end else begin
      // Long run meant to hit the limit or the label buffer
      len = $urandom_range(20, 70);
      for (int i = 0; i < len; i++)
        send_plain(($urandom_range(7) == 0) ? ale_pkg::DOT_CHAR : random_char(), 1'b0);
    end
    send_plain(BW'($urandom_range(255)), 1'b1);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [BW-1:0] sym,
                         input logic is_end, input logic typed, input logic [BW-1:0] octet,
                         input logic last, input logic err, input logic [BW-1:0] total);
    dir_row_t r;
    r.kind   = kind;
    r.symbol = sym;
    r.is_end = is_end;
    r.typed  = typed;
    r.beat   = '{octet: octet, last: last, err: err, total: total};
    dir_table.push_back(r);
  endtask

  // Result monitor
  always @(posedge clk) begin
    encoded_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("[%0t] unexpected output beat 0x%02h", $realtime, out_byte);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (out_byte !== want.octet)
          report_mismatch("out_byte", int'(out_byte), int'(want.octet));
        if (out_run_last !== want.last)
          report_mismatch("out_run_last", int'(out_run_last), int'(want.last));
        if (out_error !== want.err)
          report_mismatch("out_error", int'(out_error), int'(want.err));
        if (out_total_len !== want.total)
          report_mismatch("out_total_len", int'(out_total_len), int'(want.total));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any beat or register access.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_symbol = '0;
    in_is_end = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 7;
    recv_idle_pct = 47;
    pred_max_len = ale_pkg::MAX_LEN_RESET;
    restart_name();

    // Directed table; typed rows carry their single expected beat.
    add_row(ROW_SEND, 8'h00, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 8'd1);   // empty name
    add_row(ROW_SEND, 8'h61, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h00, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, ale_pkg::DOT_CHAR, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0); // empty labels
    add_row(ROW_SEND, ale_pkg::DOT_CHAR, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'hFF, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 8'd3);
    add_row(ROW_SEND, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'hFF, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, ale_pkg::DOT_CHAR, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h7F, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'hA5, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_CFG, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);     // zero limit
    add_row(ROW_SEND, 8'h00, 1'b1, 1'b1, 8'd0, 1'b1, 1'b1, 8'd0);
    add_row(ROW_SEND, 8'h41, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h00, 1'b1, 1'b1, 8'd0, 1'b1, 1'b1, 8'd0);
    add_row(ROW_CFG, 8'd3, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);     // limit reached exactly
    add_row(ROW_SEND, 8'h61, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h62, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h00, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h61, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h62, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h63, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h00, 1'b1, 1'b1, 8'd0, 1'b1, 1'b1, 8'd0);
    add_row(ROW_CFG, 8'd1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h00, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 8'd1);
    add_row(ROW_SEND, ale_pkg::DOT_CHAR, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h00, 1'b1, 1'b1, 8'd0, 1'b1, 1'b1, 8'd0);
    add_row(ROW_CFG, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h80, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, ale_pkg::DOT_CHAR, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    add_row(ROW_SEND, 8'h01, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) write_max_len(dir_table[i].symbol);
      else send_symbol(dir_table[i].symbol, dir_table[i].is_end,
                       dir_table[i].typed, dir_table[i].beat);
    end

    // Overlong label at the widest limit: the buffer fills, then overflows.
    send_label(ale_pkg::LABEL_DEPTH + 1);
    send_plain(8'h00, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      int stop_at;
      case (phase)
        0: begin send_idle_pct = 7;  recv_idle_pct = 47; end
        1: begin send_idle_pct = 47; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      random_limit();
      if (phase == 2) begin
        write_max_len(8'd200);
        hold_req = 1'b1;
        for (int k = 0; k < 3; k++) begin
          for (int l = 0; l < 3; l++) begin
            if (l != 0) send_plain(ale_pkg::DOT_CHAR, 1'b0);
            send_label($urandom_range(1, 4));
          end
          send_plain(BW'($urandom_range(255)), 1'b1);
        end
      end
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if ($urandom_range(7) == 0) random_limit();
        send_random_name();
      end
    end
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d input beats in %0d names, %0d output beats checked, %0d limit writes.",
             items_sent, names_sent, beats_seen, cfg_writes);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
